/* src/abf_pkg.sv */
// shared constants for the angle bisector foot pipeline
package abf_pkg;

   // extra fraction bits carried below the coordinate lsb by each distance
   localparam int SQRT_FRAC = 8;

endpackage

/* src/angle_bisector_foot.sv */
// angle bisector foot: top level with difference, square, sum, root, ratio, divide and output pipeline
// throughput: one item per cycle; busy stays low, every stage is a register step
// depth set by the root pipelines (COORD_BITS + 9 stages) and dividers (COORD_BITS stages)
// reset clears the valid bits only; items in flight at reset are dropped
// the receiver cannot stall: each result shows for exactly one cycle
module angle_bisector_foot #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_first_x,
   input  logic signed [COORD_BITS-1:0] req_first_y,
   input  logic signed [COORD_BITS-1:0] req_vertex_x,
   input  logic signed [COORD_BITS-1:0] req_vertex_y,
   input  logic signed [COORD_BITS-1:0] req_last_x,
   input  logic signed [COORD_BITS-1:0] req_last_y,
   output logic                         rsp_strobe,
   output logic signed [COORD_BITS-1:0] rsp_foot_x,
   output logic signed [COORD_BITS-1:0] rsp_foot_y,
   output logic                         rsp_degenerate
);

   localparam int C     = COORD_BITS;
   localparam int RW    = C + abf_pkg::SQRT_FRAC + 1;
   localparam int SW    = 2 * C + 1;
   localparam int NW    = C + RW;
   localparam int DW    = RW + 1;
   localparam int LAT   = C + RW + 5;
   // fraction bits only name the format; the ratio is scale free
   localparam int FRACW = FRAC_BITS;

   // difference stage
   logic [C-1:0] m1x_ff, m1y_ff, m2x_ff, m2y_ff, ldx_ff, ldy_ff;
   logic         sx_ff, sy_ff, same1_ff, v1_ff;
   logic [C-1:0] fx1_ff, fy1_ff;

   function automatic logic [C:0] sub_ext(input logic [C-1:0] a, input logic [C-1:0] b);
      sub_ext = {a[C-1], a} - {b[C-1], b};
   endfunction

   function automatic logic [C-1:0] mag_of(input logic [C:0] d);
      logic [C:0] n;
      n      = d[C] ? (~d + 1'b1) : d;
      mag_of = n[C-1:0];
   endfunction

   logic [C:0] d1x_in, d1y_in, d2x_in, d2y_in, dlx_in, dly_in;

   always_comb begin
      d1x_in = sub_ext(req_vertex_x, req_first_x);
      d1y_in = sub_ext(req_vertex_y, req_first_y);
      d2x_in = sub_ext(req_vertex_x, req_last_x);
      d2y_in = sub_ext(req_vertex_y, req_last_y);
      dlx_in = sub_ext(req_last_x, req_first_x);
      dly_in = sub_ext(req_last_y, req_first_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      m1x_ff   <= mag_of(d1x_in);
      m1y_ff   <= mag_of(d1y_in);
      m2x_ff   <= mag_of(d2x_in);
      m2y_ff   <= mag_of(d2y_in);
      ldx_ff   <= mag_of(dlx_in);
      ldy_ff   <= mag_of(dly_in);
      sx_ff    <= dlx_in[C];
      sy_ff    <= dly_in[C];
      same1_ff <= (req_first_x == req_last_x) && (req_first_y == req_last_y);
      fx1_ff   <= req_first_x;
      fy1_ff   <= req_first_y;
   end

   // square stage
   logic [2*C-1:0] q1x_ff, q1y_ff, q2x_ff, q2y_ff;
   logic [C-1:0]   ldx2_ff, ldy2_ff, fx2_ff, fy2_ff;
   logic           sx2_ff, sy2_ff, same2_ff, v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      q1x_ff   <= m1x_ff * m1x_ff;
      q1y_ff   <= m1y_ff * m1y_ff;
      q2x_ff   <= m2x_ff * m2x_ff;
      q2y_ff   <= m2y_ff * m2y_ff;
      ldx2_ff  <= ldx_ff;
      ldy2_ff  <= ldy_ff;
      fx2_ff   <= fx1_ff;
      fy2_ff   <= fy1_ff;
      sx2_ff   <= sx_ff;
      sy2_ff   <= sy_ff;
      same2_ff <= same1_ff;
   end

   // sum stage
   logic [SW-1:0] s1_ff, s2_ff;
   logic [C-1:0]  ldx3_ff, ldy3_ff, fx3_ff, fy3_ff;
   logic          sx3_ff, sy3_ff, same3_ff, v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      s1_ff    <= {1'b0, q1x_ff} + {1'b0, q1y_ff};
      s2_ff    <= {1'b0, q2x_ff} + {1'b0, q2y_ff};
      ldx3_ff  <= ldx2_ff;
      ldy3_ff  <= ldy2_ff;
      fx3_ff   <= fx2_ff;
      fy3_ff   <= fy2_ff;
      sx3_ff   <= sx2_ff;
      sy3_ff   <= sy2_ff;
      same3_ff <= same2_ff;
   end

   // root stages: sum scaled up by two fraction fields, padded to an even width
   localparam int TA_W = 2 * C + 1;
   localparam int TB_W = 2 * C + 2;

   logic [2*RW-1:0] rad1, rad2;
   logic [TA_W-1:0] tag_a_in, tag_a_out;
   logic [TB_W-1:0] tag_b_in, tag_b_out;
   logic [RW-1:0]   d1_root, d2_root;
   logic            va_out, vb_out;

   assign rad1     = {1'b0, s1_ff, {(2*abf_pkg::SQRT_FRAC){1'b0}}};
   assign rad2     = {1'b0, s2_ff, {(2*abf_pkg::SQRT_FRAC){1'b0}}};
   assign tag_a_in = {same3_ff, fx3_ff, fy3_ff};
   assign tag_b_in = {sx3_ff, sy3_ff, ldx3_ff, ldy3_ff};

   abf_sqrt #(.RW(RW), .TAG_W(TA_W)) u_sqrt_a (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .in_rad   (rad1),
      .in_tag   (tag_a_in),
      .out_valid(va_out),
      .out_root (d1_root),
      .out_tag  (tag_a_out)
   );

   abf_sqrt #(.RW(RW), .TAG_W(TB_W)) u_sqrt_b (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v3_ff),
      .in_rad   (rad2),
      .in_tag   (tag_b_in),
      .out_valid(vb_out),
      .out_root (d2_root),
      .out_tag  (tag_b_out)
   );

   // ratio stage: distance sum and scaled axis steps
   logic [DW-1:0] den_ff;
   logic [NW-1:0] nx_ff, ny_ff;
   logic [C-1:0]  fx4_ff, fy4_ff;
   logic          sx4_ff, sy4_ff, deg4_ff, v4_ff;
   logic [DW-1:0] den_in;

   assign den_in = {1'b0, d1_root} + {1'b0, d2_root};

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= va_out & vb_out;
      end
      den_ff  <= den_in;
      nx_ff   <= tag_b_out[2*C-1:C] * d1_root;
      ny_ff   <= tag_b_out[C-1:0] * d1_root;
      sx4_ff  <= tag_b_out[2*C+1];
      sy4_ff  <= tag_b_out[2*C];
      fx4_ff  <= tag_a_out[2*C-1:C];
      fy4_ff  <= tag_a_out[C-1:0];
      deg4_ff <= tag_a_out[2*C] || (den_in == '0);
   end

   // dividers
   localparam int TX_W = C + 2;
   localparam int TY_W = C + 1;

   logic [TX_W-1:0] tag_x_out;
   logic [TY_W-1:0] tag_y_out;
   logic [C-1:0]    qx, qy;
   logic            vx_out, vy_out;

   abf_div #(.QW(C), .NW(NW), .DW(DW), .TAG_W(TX_W)) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (nx_ff),
      .in_den   (den_ff),
      .in_tag   ({deg4_ff, sx4_ff, fx4_ff}),
      .out_valid(vx_out),
      .out_quo  (qx),
      .out_tag  (tag_x_out)
   );

   abf_div #(.QW(C), .NW(NW), .DW(DW), .TAG_W(TY_W)) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v4_ff),
      .in_num   (ny_ff),
      .in_den   (den_ff),
      .in_tag   ({sy4_ff, fy4_ff}),
      .out_valid(vy_out),
      .out_quo  (qy),
      .out_tag  (tag_y_out)
   );

   // output stage: apply step sign, zero the foot when degenerate
   logic [C-1:0] foot_x_in, foot_y_in;
   logic         deg_out;
   logic         strobe_ff, deg_ff;
   logic [C-1:0] foot_x_ff, foot_y_ff;

   always_comb begin
      deg_out   = tag_x_out[C+1];
      foot_x_in = tag_x_out[C] ? (tag_x_out[C-1:0] - qx) : (tag_x_out[C-1:0] + qx);
      foot_y_in = tag_y_out[C] ? (tag_y_out[C-1:0] - qy) : (tag_y_out[C-1:0] + qy);
      if (deg_out) begin
         foot_x_in = '0;
         foot_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vx_out & vy_out;
      end
      foot_x_ff <= foot_x_in;
      foot_y_ff <= foot_y_in;
      deg_ff    <= deg_out;
   end

   assign busy           = (FRACW < 0);
   assign rsp_strobe     = strobe_ff;
   assign rsp_foot_x     = foot_x_ff;
   assign rsp_foot_y     = foot_y_ff;
   assign rsp_degenerate = deg_ff;

   // every result strobe traces back to an accepted item
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without an item accepted at the pipeline depth");

   // a degenerate result carries a zero foot
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_degenerate) |-> (rsp_foot_x == '0 && rsp_foot_y == '0))
      else $error("degenerate result with nonzero foot");

   // both dividers stay in step
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      vx_out == vy_out)
      else $error("divider lanes out of step");

   // no result right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe after reset");

endmodule

/* src/abf_sqrt.sv */
// pipelined floor square root, one root bit per stage, with a tag carried alongside
module abf_sqrt #(
   parameter int RW    = 25,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [2*RW-1:0]   in_rad,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [RW-1:0]     out_root,
   output logic [TAG_W-1:0]  out_tag
);

   localparam int REM_W = RW + 2;

   logic [REM_W-1:0]  rem_ff  [1:RW];
   logic [RW-1:0]     root_ff [1:RW];
   logic [2*RW-1:0]   rad_ff  [1:RW];
   logic [TAG_W-1:0]  tag_ff  [1:RW];
   logic              vld_ff  [1:RW];

   for (genvar k = 0; k < RW; k++) begin : g_stage
      logic [REM_W-1:0]  cur_rem;
      logic [RW-1:0]     cur_root;
      logic [2*RW-1:0]   cur_rad;
      logic [TAG_W-1:0]  cur_tag;
      logic              cur_vld;
      logic [REM_W+1:0]  part;
      logic [REM_W+1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [RW-1:0]     root_in;

      // stage source: ports for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
         assign cur_rem  = '0;
         assign cur_root = '0;
         assign cur_rad  = in_rad;
         assign cur_tag  = in_tag;
         assign cur_vld  = in_valid;
      end else begin : g_next
         assign cur_rem  = rem_ff[k];
         assign cur_root = root_ff[k];
         assign cur_rad  = rad_ff[k];
         assign cur_tag  = tag_ff[k];
         assign cur_vld  = vld_ff[k];
      end

      // bring down two radicand bits and try the next root bit
      always_comb begin
         part  = {cur_rem, cur_rad[2*RW-1 -: 2]};
         trial = {2'b00, cur_root, 2'b01};
         if (part >= trial) begin
            rem_in  = REM_W'(part - trial);
            root_in = {cur_root[RW-2:0], 1'b1};
         end else begin
            rem_in  = part[REM_W-1:0];
            root_in = {cur_root[RW-2:0], 1'b0};
         end
      end

      // stage registers
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= cur_vld;
         end
         rem_ff[k+1]  <= rem_in;
         root_ff[k+1] <= root_in;
         rad_ff[k+1]  <= {cur_rad[2*RW-3:0], 2'b00};
         tag_ff[k+1]  <= cur_tag;
      end
   end

   assign out_valid = vld_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_tag   = tag_ff[RW];

endmodule

/* src/abf_div.sv */
// pipelined restoring divider, one quotient bit per stage, with a tag carried alongside
module abf_div #(
   parameter int QW    = 16,
   parameter int NW    = 41,
   parameter int DW    = 26,
   parameter int TAG_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NW-1:0]     in_num,
   input  logic [DW-1:0]     in_den,
   input  logic [TAG_W-1:0]  in_tag,
   output logic              out_valid,
   output logic [QW-1:0]     out_quo,
   output logic [TAG_W-1:0]  out_tag
);

   logic [DW-1:0]     rem_ff [1:QW];
   logic [QW-1:0]     low_ff [1:QW];
   logic [QW-1:0]     quo_ff [1:QW];
   logic [DW-1:0]     den_ff [1:QW];
   logic [TAG_W-1:0]  tag_ff [1:QW];
   logic              vld_ff [1:QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0]     cur_rem;
      logic [QW-1:0]     cur_low;
      logic [QW-1:0]     cur_quo;
      logic [DW-1:0]     cur_den;
      logic [TAG_W-1:0]  cur_tag;
      logic              cur_vld;
      logic [DW:0]       part;
      logic [DW-1:0]     rem_in;
      logic              bit_in;

      // high part of the dividend starts as the remainder, it is below the divisor
      if (k == 0) begin : g_first
         assign cur_rem = DW'(in_num[NW-1:QW]);
         assign cur_low = in_num[QW-1:0];
         assign cur_quo = '0;
         assign cur_den = in_den;
         assign cur_tag = in_tag;
         assign cur_vld = in_valid;
      end else begin : g_next
         assign cur_rem = rem_ff[k];
         assign cur_low = low_ff[k];
         assign cur_quo = quo_ff[k];
         assign cur_den = den_ff[k];
         assign cur_tag = tag_ff[k];
         assign cur_vld = vld_ff[k];
      end

      // shift in one dividend bit, subtract when it fits
      always_comb begin
         part = {cur_rem, cur_low[QW-1]};
         if (part >= {1'b0, cur_den}) begin
            rem_in = DW'(part - {1'b0, cur_den});
            bit_in = 1'b1;
         end else begin
            rem_in = part[DW-1:0];
            bit_in = 1'b0;
         end
      end

      // stage registers
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= cur_vld;
         end
         rem_ff[k+1] <= rem_in;
         low_ff[k+1] <= {cur_low[QW-2:0], 1'b0};
         quo_ff[k+1] <= {cur_quo[QW-2:0], bit_in};
         den_ff[k+1] <= cur_den;
         tag_ff[k+1] <= cur_tag;
      end
   end

   assign out_valid = vld_ff[QW];
   assign out_quo   = quo_ff[QW];
   assign out_tag   = tag_ff[QW];

endmodule

/* verif/tb_angle_bisector_foot.sv */
// testbench for the angle bisector foot pipeline: directed table, then random point triples
module tb_angle_bisector_foot;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = 16;
   localparam int LATENCY = 2 * CB + 14;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type fx, fy, vx, vy, lx, ly;
   } triple_type;

   typedef struct {
      coord_type foot_x, foot_y;
      logic      degenerate;
   } foot_type;

   typedef struct {
      triple_type pts;
      bit         typed;
      foot_type   want;
   } row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_first_x = '0, req_first_y = '0, req_vertex_x = '0;
   coord_type req_vertex_y = '0, req_last_x = '0, req_last_y = '0;
   logic      rsp_strobe;
   coord_type rsp_foot_x, rsp_foot_y;
   logic      rsp_degenerate;

   foot_type  pending_feet[$];
   int        errors = 0;

   angle_bisector_foot #(.COORD_BITS(CB), .FRAC_BITS(4)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_vertex_x(req_vertex_x), .req_vertex_y(req_vertex_y),
      .req_last_x(req_last_x), .req_last_y(req_last_y),
      .rsp_strobe(rsp_strobe), .rsp_foot_x(rsp_foot_x), .rsp_foot_y(rsp_foot_y),
      .rsp_degenerate(rsp_degenerate)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop
   initial begin
      #5ms;
      $display("== FAIL ==");
      $finish;
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   // floor square root of a 64-bit value
   function automatic longint unsigned floor_root(input longint unsigned n);
      longint unsigned r, t;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= n) r = t;
      end
      return r;
   endfunction

   // distance carried with SQRT_FRAC extra fraction bits
   function automatic longint unsigned seg_length(input longint dx, input longint dy);
      longint unsigned s;
      s = longint'(dx * dx) + longint'(dy * dy);
      return floor_root(s << (2 * abf_pkg::SQRT_FRAC));
   endfunction

   // one axis: f + (l - f) * d1 / den, truncated toward zero
   function automatic coord_type axis_foot(input longint f, input longint l,
                                           input longint unsigned d1,
                                           input longint unsigned den);
      longint diff, step;
      longint unsigned q;
      diff = l - f;
      q = ((diff < 0 ? -diff : diff) * d1) / den;
      step = diff < 0 ? -longint'(q) : longint'(q);
      return coord_type'(f + step);
   endfunction

   function automatic foot_type predict_foot(input triple_type p);
      foot_type r;
      longint unsigned d1, d2;
      d1 = seg_length(longint'(p.vx) - p.fx, longint'(p.vy) - p.fy);
      d2 = seg_length(longint'(p.vx) - p.lx, longint'(p.vy) - p.ly);
      if ((p.fx == p.lx && p.fy == p.ly) || d1 + d2 == 0) begin
         r = '{'0, '0, 1'b1};
      end else begin
         r.foot_x = axis_foot(p.fx, p.lx, d1, d1 + d2);
         r.foot_y = axis_foot(p.fy, p.ly, d1, d1 + d2);
         r.degenerate = 1'b0;
      end
      return r;
   endfunction

   // present one item and hold it until accepted
   task automatic send_item(input triple_type p, input foot_type want);
      start <= 1'b1;
      req_first_x <= p.fx;  req_first_y <= p.fy;
      req_vertex_x <= p.vx; req_vertex_y <= p.vy;
      req_last_x <= p.lx;   req_last_y <= p.ly;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_feet.push_back(want);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   function automatic coord_type rand_coord(input bit near);
      return near ? coord_type'($urandom_range(0, 255) - 128) : coord_type'($urandom);
   endfunction

   function automatic triple_type rand_triple();
      triple_type p;
      bit near;
      near = $urandom_range(0, 2) == 0;
      p = '{rand_coord(near), rand_coord(near), rand_coord(near),
            rand_coord(near), rand_coord(near), rand_coord(near)};
      case ($urandom_range(0, 9))
         0: begin
            p.lx = p.fx; p.ly = p.fy;
         end
         1: begin
            p.vx = p.fx; p.vy = p.fy;
         end
         2: begin
            p.vx = p.lx; p.vy = p.ly;
         end
         3: begin
            p.vx = p.fx; p.vy = p.fy; p.lx = p.fx; p.ly = p.fy;
         end
         default: ;
      endcase
      return p;
   endfunction

   // result checker
   always @(posedge clock) begin
      foot_type want;
      if (!reset && rsp_strobe) begin
         if (pending_feet.size() == 0) begin
            report("result with no item outstanding");
         end else begin
            want = pending_feet.pop_front();
            if (rsp_foot_x !== want.foot_x)
               report($sformatf("foot_x %0d want %0d", rsp_foot_x, want.foot_x));
            if (rsp_foot_y !== want.foot_y)
               report($sformatf("foot_y %0d want %0d", rsp_foot_y, want.foot_y));
            if (rsp_degenerate !== want.degenerate)
               report($sformatf("degenerate %0b want %0b", rsp_degenerate,
                                want.degenerate));
         end
      end
   end

   // stimulus
   initial begin
      localparam coord_type MINC = coord_type'(16'h8000);
      localparam coord_type MAXC = coord_type'(16'h7fff);
      row_type table_rows[$];
      triple_type p;
      foot_type none;
      int burst, waited;

      none = '{'0, '0, 1'b0};
      // coinciding ends, all points equal, vertex on an end, extremes
      table_rows = '{
         '{'{0, 0, 0, 0, 0, 0}, 1, '{0, 0, 1'b1}},
         '{'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC}, 1, '{0, 0, 1'b1}},
         '{'{MINC, MINC, MINC, MINC, MINC, MINC}, 1, '{0, 0, 1'b1}},
         '{'{MINC, MAXC, 0, 0, MINC, MAXC}, 1, '{0, 0, 1'b1}},
         '{'{MINC, MINC, MINC, MINC, MAXC, MAXC}, 1, '{MINC, MINC, 1'b0}},
         '{'{MINC, MINC, MAXC, MAXC, MAXC, MAXC}, 1, '{MAXC, MAXC, 1'b0}},
         '{'{MAXC, MINC, MAXC, MINC, MINC, MAXC}, 1, '{MAXC, MINC, 1'b0}},
         '{'{MAXC, MINC, MINC, MAXC, MINC, MAXC}, 1, '{MINC, MAXC, 1'b0}},
         '{'{MINC, 0, 0, MAXC, MAXC, 0}, 0, none},
         '{'{MINC, MINC, MAXC, MINC, MAXC, MAXC}, 0, none},
         '{'{MAXC, MAXC, MINC, MINC, MAXC, MINC}, 0, none},
         '{'{0, 0, 16, 16, 32, 0}, 0, none},
         '{'{-16, 0, 0, 48, 16, 0}, 0, none},
         '{'{1, 1, 0, 0, -1, -1}, 0, none},
         '{'{0, 0, 1, 0, 1, 1}, 0, none},
         '{'{100, -200, 5, 5, -300, 400}, 0, none},
         '{'{MINC, MINC, 0, 0, MAXC, MAXC}, 0, none},
         '{'{-1, -1, -1, -1, -1, 0}, 0, none}
      };

      // hold reset, then release it
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (table_rows[i])
         send_item(table_rows[i].pts, table_rows[i].typed ? table_rows[i].want
                                                        : predict_foot(table_rows[i].pts));
      idle_gap($urandom_range(1, 4));

      // random bursts with random gaps
      for (int n = 0; n < 1050; ) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && n < 1050; k++, n++) begin
            p = rand_triple();
            send_item(p, predict_foot(p));
         end
         idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
      end
      start <= 1'b0;

      // drain outstanding results
      waited = 0;
      while (pending_feet.size() != 0 && waited < 20 * LATENCY) begin
         @(posedge clock);
         waited++;
      end
      repeat (LATENCY + 10) @(posedge clock);

      if (errors == 0 && pending_feet.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
src/abf_pkg.sv
src/abf_sqrt.sv
src/abf_div.sv
src/angle_bisector_foot.sv
verif/tb_angle_bisector_foot.sv
